/* rtl/core/ax25hp_pkg.sv */
`default_nettype none
package ax25hp_pkg;

  localparam int unsigned MAX_REPEATERS_DEF = 2;
  localparam int unsigned MIN_FRAME = 7 + 7 + 2;
  localparam logic [7:0] PID_RESET = 8'hF0;
  localparam logic [7:0] CTRL_UI = 8'h03;
  localparam logic [6:0] CHAR_SPACE = 7'h20;

  typedef enum logic [2:0] {
    PH_DST  = 3'd0,
    PH_SRC  = 3'd1,
    PH_RPT  = 3'd2,
    PH_CTRL = 3'd3,
    PH_PID  = 3'd4,
    PH_DATA = 3'd5,
    PH_DROP = 3'd6
  } phase_t;

  localparam logic [1:0] KIND_ADDR    = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_DST_LAST  = 3'd2;
  localparam logic [2:0] ST_CUT_RPT   = 3'd3;
  localparam logic [2:0] ST_MANY_RPT  = 3'd4;
  localparam logic [2:0] ST_NO_CTRL   = 3'd5;
  localparam logic [2:0] ST_MISMATCH  = 3'd6;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  addr_role;
    logic [2:0]  repeater_index;
    logic [47:0] callsign;
    logic [2:0]  callsign_len;
    logic [3:0]  ssid;
    logic        cr_bit;
    logic [7:0]  payload_byte;
    logic        frame_end;
    logic [2:0]  status;
  } result_t;

endpackage
`default_nettype wire

/* rtl/core/ax25_header_parser.sv */
`default_nettype none
// AX.25 header parser: takes one deframed frame byte per cycle (checksum removed, tlast on the
// final byte) and emits decoded addresses, payload bytes and a closing status. Every byte is
// handled in the cycle it is accepted, and its result, if any, appears on the registered output
// on the next cycle, so sustained throughput is one byte per clock; the only stall is
// back-pressure on the output register, which passes straight through to s_axis_tready.
// A nonzero status on the tlast result means the addresses already sent must be discarded.
module ax25_header_parser import ax25hp_pkg::*; #(
  parameter int unsigned MAX_REPEATERS = MAX_REPEATERS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte
  input  wire logic        s_axis_tlast,   // last_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // addr_role[1:0], repeater_index[4:2], callsign[52:5], callsign_len[55:53],
  // ssid[59:56], cr_bit[60], payload_byte[68:61], status[71:69]
  output logic [71:0]      m_axis_tdata,
  output logic             m_axis_tlast,   // frame_end
  output logic [1:0]       m_axis_tuser,   // kind
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data        // expected_pid
);

  logic [7:0] expected_pid;
  logic       accept;
  logic       have;
  result_t    res;
  result_t    out_res;
  logic       out_valid;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = ~out_valid | m_axis_tready;
  assign accept        = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_pid <= PID_RESET;
    end else if (cfg_valid) begin
      expected_pid <= cfg_data;
    end
  end

  ax25hp_parse #(
    .MAX_REPEATERS(MAX_REPEATERS)
  ) u_parse (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (s_axis_tdata),
    .last_byte    (s_axis_tlast),
    .expected_pid (expected_pid),
    .res          (res),
    .have         (have)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && have) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && have) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_res.frame_end;
  assign m_axis_tuser  = out_res.kind;
  assign m_axis_tdata  = {out_res.status, out_res.payload_byte, out_res.cr_bit, out_res.ssid,
                          out_res.callsign_len, out_res.callsign, out_res.repeater_index,
                          out_res.addr_role};

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");
  a_status_on_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> out_res.status == ST_OK && out_res.kind != KIND_STATUS)
    else $error("status reported before frame end");
  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_res.kind == KIND_PAYLOAD |-> out_res.callsign == '0)
    else $error("address fields set on payload transaction");
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> out_res.kind == KIND_ADDR || out_res.kind == KIND_PAYLOAD
                      || out_res.kind == KIND_STATUS)
    else $error("bad result kind");
`endif

endmodule
`default_nettype wire

/* rtl/core/ax25hp_parse.sv */
`default_nettype none
module ax25hp_parse import ax25hp_pkg::*; #(
  parameter int unsigned MAX_REPEATERS = MAX_REPEATERS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  input  wire logic [7:0] expected_pid,
  output result_t         res,
  output logic            have
);

  phase_t      phase, phase_next;
  logic [2:0]  field_byte_index, field_byte_index_next;
  logic [3:0]  repeater_count, repeater_count_next;
  logic [4:0]  frame_byte_count, frame_byte_count_next;
  logic [47:0] callsign_shift, callsign_shift_next;
  logic [2:0]  callsign_length, callsign_length_next;
  logic        space_seen, space_seen_next;
  logic [2:0]  first_error, first_error_next;
  logic [7:0]  control_hold, control_hold_next;

  logic [6:0]  ch;
  logic        more;
  logic        blank;

  assign ch    = data_byte[7:1];
  assign more  = ~data_byte[0];
  assign blank = space_seen | (ch == CHAR_SPACE);

  always_comb begin
    phase_next            = phase;
    field_byte_index_next = field_byte_index;
    repeater_count_next   = repeater_count;
    frame_byte_count_next = frame_byte_count;
    callsign_shift_next   = callsign_shift;
    callsign_length_next  = callsign_length;
    space_seen_next       = space_seen;
    first_error_next      = first_error;
    control_hold_next     = control_hold;
    res                   = '0;
    have                  = 1'b0;

    if (frame_byte_count < 5'(MIN_FRAME)) begin
      frame_byte_count_next = frame_byte_count + 5'd1;
    end

    case (phase)
      PH_DST, PH_SRC, PH_RPT: begin
        if (field_byte_index < 3'd6) begin
          space_seen_next = blank;
          if (!blank) begin
            callsign_length_next = callsign_length + 3'd1;
          end
          callsign_shift_next = {callsign_shift[39:0], blank ? 8'd0 : {1'b0, ch}};
          field_byte_index_next = field_byte_index + 3'd1;
        end else begin
          have               = 1'b1;
          res.kind           = KIND_ADDR;
          res.addr_role      = phase[1:0];
          res.repeater_index = (phase == PH_RPT) ? repeater_count[2:0] : 3'd0;
          res.callsign       = callsign_shift;
          res.callsign_len   = callsign_length;
          res.ssid           = data_byte[4:1];
          res.cr_bit         = data_byte[7];
          field_byte_index_next = 3'd0;
          callsign_shift_next   = '0;
          callsign_length_next  = 3'd0;
          space_seen_next       = 1'b0;
          case (phase)
            PH_DST: begin
              if (more) begin
                phase_next = PH_SRC;
              end else begin
                phase_next = PH_DROP;
                if (first_error == ST_OK) first_error_next = ST_DST_LAST;
              end
            end
            PH_SRC: begin
              phase_next = more ? PH_RPT : PH_CTRL;
            end
            default: begin
              if (repeater_count != 4'd15) begin
                repeater_count_next = repeater_count + 4'd1;
              end
              if (!more) begin
                phase_next = PH_CTRL;
              end else if (repeater_count_next >= 4'(MAX_REPEATERS)) begin
                phase_next = PH_DROP;
                if (first_error == ST_OK) first_error_next = ST_MANY_RPT;
              end
            end
          endcase
        end
      end
      PH_CTRL: begin
        control_hold_next = data_byte;
        phase_next        = PH_PID;
      end
      PH_PID: begin
        if (control_hold != CTRL_UI || data_byte != expected_pid) begin
          phase_next = PH_DROP;
          if (first_error == ST_OK) first_error_next = ST_MISMATCH;
        end else begin
          phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        have             = 1'b1;
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = data_byte;
      end
      default: ;
    endcase

    if (last_byte) begin
      // status looks at the state after this byte
      if (frame_byte_count_next < 5'(MIN_FRAME)) begin
        res.status = ST_SHORT;
      end else if (first_error_next != ST_OK) begin
        res.status = first_error_next;
      end else begin
        case (phase_next)
          PH_RPT:          res.status = ST_CUT_RPT;
          PH_CTRL, PH_PID: res.status = ST_NO_CTRL;
          PH_DATA:         res.status = ST_OK;
          default:         res.status = ST_SHORT;
        endcase
      end
      if (!have) begin
        res.kind = KIND_STATUS;
      end
      have          = 1'b1;
      res.frame_end = 1'b1;
      phase_next            = PH_DST;
      repeater_count_next   = 4'd0;
      frame_byte_count_next = 5'd0;
      first_error_next      = ST_OK;
      control_hold_next     = 8'd0;
      field_byte_index_next = 3'd0;
      callsign_shift_next   = '0;
      callsign_length_next  = 3'd0;
      space_seen_next       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_DST;
      field_byte_index <= 3'd0;
      repeater_count   <= 4'd0;
      frame_byte_count <= 5'd0;
      callsign_shift   <= '0;
      callsign_length  <= 3'd0;
      space_seen       <= 1'b0;
      first_error      <= ST_OK;
      control_hold     <= 8'd0;
    end else if (accept) begin
      phase            <= phase_next;
      field_byte_index <= field_byte_index_next;
      repeater_count   <= repeater_count_next;
      frame_byte_count <= frame_byte_count_next;
      callsign_shift   <= callsign_shift_next;
      callsign_length  <= callsign_length_next;
      space_seen       <= space_seen_next;
      first_error      <= first_error_next;
      control_hold     <= control_hold_next;
    end
  end

`ifndef SYNTHESIS
  // once an error is latched the frame is dropped until its end
  a_err_drops: assert property (@(posedge clk) disable iff (rst)
    first_error != ST_OK |-> phase == PH_DROP)
    else $error("error held outside drop phase");
  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    frame_byte_count <= 5'(MIN_FRAME))
    else $error("frame byte count past saturation");
  a_last_has_result: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |-> have && res.frame_end)
    else $error("final byte without closing result");
`endif

endmodule
`default_nettype wire
